// ===== src/pcx_pkg.sv =====
// ----------------------------------------------------------------------------
// pcx_pkg
// Types and constants shared by the PCX run-length row decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pcx_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned PosW   = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] FLAG_MASK = 8'hC0;

  localparam logic [1:0] STATUS_PIXEL = 2'd0;
  localparam logic [1:0] STATUS_JUNK  = 2'd1;
  localparam logic [1:0] STATUS_EOS   = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ROW_LEN   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] pixel_value;
    logic [1:0]       status;
    logic             row_end;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic run_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic more;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/pcx_stream_if.sv =====
// ----------------------------------------------------------------------------
// pcx_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcx_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/pcx_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcx_ctrl
// Controller: takes beats when idle, one run pixel a cycle when output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire pcx_pkg::sts_t sts_i,
  output pcx_pkg::cmd_t     cmd_o
);
  import pcx_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state_q, state_d;

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    state_d      = state_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = sts_i.out_free;
        cmd_o.accept = in_valid_i & sts_i.out_free;
        if (cmd_o.accept && sts_i.more) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.run_step = sts_i.out_free;
        if (cmd_o.run_step && !sts_i.more) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/pcx_dp.sv =====
// ----------------------------------------------------------------------------
// pcx_dp
// Datapath: decode state, row/column counters, config and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pcx_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [pcx_pkg::PosW-1:0]       cfg_wdata_i,
  input  wire pcx_pkg::in_item_t              in_data_i,
  input  wire pcx_pkg::cmd_t                  cmd_i,
  output pcx_pkg::sts_t                       sts_o,
  input  wire logic                           out_ready_i,
  output logic                                out_valid_o,
  output pcx_pkg::out_item_t                  out_data_o
);
  import pcx_pkg::*;

  logic [PosW-1:0]   bpr_q, rows_q;
  logic              pending_q, pending_d;
  logic [CountW-1:0] rep_q, rep_d;
  logic [PosW-1:0]   col_q, col_d, row_q, row_d;
  logic              stopped_q, stopped_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [ByteW-1:0]  pix_q, pix_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              live, is_count, run_start, step, junk, wrap, eos_err;
  logic [CountW-1:0] times_in, step_times;
  logic [ByteW-1:0]  step_pix;
  logic [PosW-1:0]   col_inc;

  assign live      = cmd_i.accept & ~stopped_q;
  assign is_count  = (in_data_i.data_byte & FLAG_MASK) == FLAG_MASK;
  assign times_in  = pending_q ? rep_q : CountW'(1);
  assign run_start = live & ~in_data_i.end_of_stream &
                     (pending_q ? (rep_q != '0) : ~is_count);
  assign eos_err   = live & in_data_i.end_of_stream & pending_q;
  assign step      = run_start | cmd_i.run_step;
  assign step_times = cmd_i.run_step ? rem_q : times_in;
  assign step_pix  = cmd_i.run_step ? pix_q : ~in_data_i.data_byte;
  assign junk      = row_q >= rows_q;
  assign col_inc   = col_q + PosW'(1);
  assign wrap      = col_inc == bpr_q;

  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign sts_o.more     = step & ~junk & (step_times != CountW'(1));

  always_comb begin
    pending_d   = pending_q;
    rep_d       = rep_q;
    col_d       = col_q;
    row_d       = row_q;
    stopped_d   = stopped_q;
    rem_d       = rem_q;
    pix_d       = pix_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    if (live) begin
      if (in_data_i.end_of_stream || pending_q) begin
        pending_d = 1'b0;
        rep_d     = '0;
      end else if (is_count) begin
        pending_d = 1'b1;
        rep_d     = in_data_i.data_byte[CountW-1:0];
      end
    end

    if (eos_err) begin
      out_valid_d = 1'b1;
      out_d       = '{pixel_value: '0, status: STATUS_EOS, row_end: 1'b0,
                      last_of_run: 1'b1};
    end

    if (step) begin
      out_valid_d = 1'b1;
      rem_d       = step_times - CountW'(1);
      pix_d       = step_pix;
      if (junk) begin
        stopped_d = 1'b1;
        out_d     = '{pixel_value: '0, status: STATUS_JUNK, row_end: 1'b0,
                      last_of_run: 1'b1};
      end else begin
        col_d = wrap ? '0 : col_inc;
        if (wrap) begin
          row_d = row_q + PosW'(1);
        end
        out_d = '{pixel_value: step_pix, status: STATUS_PIXEL, row_end: wrap,
                  last_of_run: step_times == CountW'(1)};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpr_q       <= PosW'(1);
      rows_q      <= PosW'(1);
      pending_q   <= 1'b0;
      rep_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROW_LEN:   bpr_q  <= cfg_wdata_i;
          CFG_ROW_COUNT: rows_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      pending_q   <= pending_d;
      rep_q       <= rep_d;
      col_q       <= col_d;
      row_q       <= row_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    pix_q <= pix_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== src/pcx_rle_row_decoder.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_row_decoder
// PCX run-length decoder that emits inverted pixels counted into rows.
// ----------------------------------------------------------------------------
//  port     dir  beat
//  in_i     in   data_byte[7:0], end_of_stream
//  out_o    out  pixel_value[7:0], status[1:0], row_end, last_of_run
//  cfg_*    in   write-only: 0 row length, 1 row_count (16 bit)
//
//  A literal byte or a count byte is taken on its own beat; a run's first
//  pixel comes on the beat that carries the run byte, with input stalled
//  for the rest: one pixel per cycle from the run stepper when out is free.
//  Results sit in a registered output stage; input is taken while it drains.
//  Reset clears all state but stepper and output data; both registers go to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_row_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [pcx_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [pcx_pkg::PosW-1:0]    cfg_wdata_i,
  pcx_stream_if.sink                       in_i,
  pcx_stream_if.source                     out_o
);
  import pcx_pkg::*;

  cmd_t      cmd;
  sts_t      sts;
  logic      out_valid;
  out_item_t out_data;
  in_item_t  in_data;

  assign in_data = in_i.data;

  pcx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcx_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCX run-length row decoder. A short table of
// directed beats covers literals, count bytes, zero and maximum repeats,
// end of stream inside a run, and register extremes. Random phases follow,
// each with its own row length and row count, under random gaps on both
// channels but for one steady phase. The run ends by filling the image so
// that the junk status fires mid-run and later input is ignored. Every
// result is checked field by field against an in-bench model or the table.
// ----------------------------------------------------------------------------

module tb;
  import pcx_pkg::*;

  typedef struct {
    bit              is_cfg;
    logic [PosW-1:0] bpr;
    logic [PosW-1:0] rc;
    in_item_t        beat;
    bit              typed;
    out_item_t       want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [PosW-1:0]    cfg_wdata;
  bit                 beat_typed;
  out_item_t          beat_want;
  bit                 steady;

  pcx_stream_if #(.payload_t(in_item_t))  in_if ();
  pcx_stream_if #(.payload_t(out_item_t)) out_if ();

  pcx_rle_row_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #5 clk_i = ~clk_i;

  // decoder model state
  logic [PosW-1:0]   row_len    = 16'd1;
  logic [PosW-1:0]   rows_total = 16'd1;
  logic              run_armed  = 1'b0;
  logic [CountW-1:0] run_len    = '0;
  logic [PosW-1:0]   col_pos    = '0;
  logic [PosW-1:0]   row_pos    = '0;
  logic              halted     = 1'b0;

  out_item_t fresh_q[$];
  out_item_t decoded_q[$];
  out_item_t seen, due;
  row_t      plan[$];

  int errors, beats_in, pixels, row_ends, eos_errs, junks;

  function automatic out_item_t res_of(logic [7:0] pix, logic [1:0] st, logic re, logic last);
    return '{pixel_value: pix, status: st, row_end: re, last_of_run: last};
  endfunction

  function automatic row_t beat_r(logic [7:0] d, logic e);
    row_t r;
    r.is_cfg = 1'b0;
    r.bpr    = '0;
    r.rc     = '0;
    r.beat   = in_item_t'{d, e};
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic row_t check_r(logic [7:0] d, logic e, out_item_t want);
    row_t r;
    r       = beat_r(d, e);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t cfg_r(logic [PosW-1:0] bpr, logic [PosW-1:0] rc);
    row_t r;
    r        = beat_r(8'h00, 1'b0);
    r.is_cfg = 1'b1;
    r.bpr    = bpr;
    r.rc     = rc;
    return r;
  endfunction

  function automatic void emit_pixels(logic [7:0] raw, int reps);
    logic re;
    for (int i = 0; i < reps; i++) begin
      if (row_pos >= rows_total) begin
        fresh_q.push_back(res_of(8'h00, STATUS_JUNK, 1'b0, 1'b1));
        halted = 1'b1;
        return;
      end
      col_pos = col_pos + 16'd1;
      re = 1'b0;
      if (col_pos == row_len) begin
        col_pos = '0;
        row_pos = row_pos + 16'd1;
        re = 1'b1;
      end
      fresh_q.push_back(res_of(8'd255 - raw, STATUS_PIXEL, re, i == reps - 1));
    end
  endfunction

  function automatic void decode_byte(in_item_t b);
    int reps;
    if (halted) return;
    if (b.end_of_stream) begin
      if (run_armed) begin
        run_armed = 1'b0;
        run_len   = '0;
        fresh_q.push_back(res_of(8'h00, STATUS_EOS, 1'b0, 1'b1));
      end
      return;
    end
    if (run_armed) begin
      reps = run_len;
      run_armed = 1'b0;
      run_len   = '0;
      emit_pixels(b.data_byte, reps);
    end else if ((b.data_byte & FLAG_MASK) == FLAG_MASK) begin
      run_armed = 1'b1;
      run_len   = b.data_byte[CountW-1:0];
    end else begin
      emit_pixels(b.data_byte, 1);
    end
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // accepted beats are decoded before results are checked, in one process
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      fresh_q.delete();
      decode_byte(in_if.data);
      beats_in++;
      if (beat_typed) decoded_q.push_back(beat_want);
      else foreach (fresh_q[i]) decoded_q.push_back(fresh_q[i]);
    end
    if (out_if.valid && out_if.ready) begin
      seen = out_if.data;
      if (decoded_q.size() == 0) begin
        report($sformatf("result %h with nothing expected", seen));
      end else begin
        due = decoded_q.pop_front();
        check_field("pixel_value", seen.pixel_value, due.pixel_value);
        check_field("status", seen.status, due.status);
        check_field("row_end", seen.row_end, due.row_end);
        check_field("last_of_run", seen.last_of_run, due.last_of_run);
        if (due.status == STATUS_PIXEL) pixels++;
        else if (due.status == STATUS_JUNK) junks++;
        else eos_errs++;
        row_ends += due.row_end;
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= steady || ($urandom_range(0, 99) >= 11);
    end
  end

  task automatic push_beat(in_item_t b, bit typed, out_item_t want);
    int gap;
    gap = (!steady && $urandom_range(0, 99) < 11) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    beat_typed  <= typed;
    beat_want   <= want;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [PosW-1:0] bpr, logic [PosW-1:0] rc);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ROW_LEN;
    cfg_wdata <= bpr;
    @(posedge clk_i);
    cfg_idx   <= CFG_ROW_COUNT;
    cfg_wdata <= rc;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    row_len    = bpr;
    rows_total = rc;
  endtask

  task automatic walk_plan();
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_cfg(plan[i].bpr, plan[i].rc);
      end else begin
        push_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end
  endtask

  task automatic random_phase(int quota);
    int sent;
    int pick;
    logic [5:0] len;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        push_beat(in_item_t'{8'($urandom_range(0, 191)), 1'b0}, 1'b0, '0);
        sent += 1;
      end else if (pick < 75) begin
        len = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 8));
        push_beat(in_item_t'{8'hC0 | {2'b00, len}, 1'b0}, 1'b0, '0);
        push_beat(in_item_t'{8'($urandom_range(0, 255)), 1'b0}, 1'b0, '0);
        sent += 2;
      end else if (pick < 83) begin
        // run cut short by end of stream
        push_beat(in_item_t'{8'hC0 | 8'($urandom_range(0, 63)), 1'b0}, 1'b0, '0);
        push_beat(in_item_t'{8'($urandom_range(0, 255)), 1'b1}, 1'b0, '0);
        sent += 2;
      end else if (pick < 90) begin
        push_beat(in_item_t'{8'($urandom_range(0, 255)), 1'b1}, 1'b0, '0);
        sent += 1;
      end else begin
        push_beat(in_item_t'{8'($urandom_range(0, 255)), 1'b0}, 1'b0, '0);
        sent += 1;
      end
      if ($urandom_range(0, 99) == 0) settle();
    end
  endtask

  initial begin
    int pick;
    int rc_lo;
    rst_ni      <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_ROW_LEN;
    cfg_wdata   <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    beat_typed  <= 1'b0;
    beat_want   <= '0;
    steady       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan = '{
      check_r(8'h00, 1'b0, res_of(8'hFF, STATUS_PIXEL, 1'b1, 1'b1)),
      cfg_r(16'd3, 16'hFFFF),
      check_r(8'h00, 1'b0, res_of(8'hFF, STATUS_PIXEL, 1'b0, 1'b1)),
      check_r(8'hBF, 1'b0, res_of(8'h40, STATUS_PIXEL, 1'b0, 1'b1)),
      check_r(8'h7F, 1'b0, res_of(8'h80, STATUS_PIXEL, 1'b1, 1'b1)),
      beat_r(8'hC0, 1'b0), beat_r(8'h12, 1'b0),
      beat_r(8'hC1, 1'b0),
      check_r(8'hFF, 1'b0, res_of(8'h00, STATUS_PIXEL, 1'b0, 1'b1)),
      beat_r(8'hFF, 1'b0), beat_r(8'h80, 1'b0),
      beat_r(8'hC3, 1'b0),
      check_r(8'hAA, 1'b1, res_of(8'h00, STATUS_EOS, 1'b0, 1'b1)),
      beat_r(8'h5A, 1'b1),
      beat_r(8'hC2, 1'b0), beat_r(8'hC5, 1'b0),
      cfg_r(16'hFFFF, 16'hFFFF),
      beat_r(8'h40, 1'b0), beat_r(8'hFE, 1'b0), beat_r(8'h01, 1'b0),
      cfg_r(16'd0, 16'hFFFF),
      beat_r(8'hC4, 1'b0), beat_r(8'h55, 1'b0),
      cfg_r(16'd2, 16'hFFFF),     // column already past the new row length
      beat_r(8'hC3, 1'b0), beat_r(8'h77, 1'b0),
      cfg_r(16'd2, 16'd0),        // no pixel may be written now
      beat_r(8'hC7, 1'b0),
      check_r(8'h33, 1'b1, res_of(8'h00, STATUS_EOS, 1'b0, 1'b1)),
      beat_r(8'hC0, 1'b0), beat_r(8'h09, 1'b0)
    };
    walk_plan();

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0:       pick = $urandom_range(1, 8);
        1:       pick = 65535;
        2:       pick = $urandom_range(1, 300);
        3:       pick = 0;
        4:       pick = $urandom_range(2, 40);
        default: pick = $urandom_range(1, 4000);
      endcase
      // keep rows ending: row length beyond the current column
      if (pick != 0 && pick <= col_pos) pick = col_pos + $urandom_range(1, 6);
      // a phase writes at most 68 * 63 rows, so the image never fills here
      rc_lo = row_pos + 4500;
      write_cfg(16'(pick), (rc_lo >= 65535) ? 16'hFFFF : 16'($urandom_range(rc_lo, 65535)));
      steady = (p == 1);
      random_phase(68);
    end
    steady = 1'b0;

    // fill the image: one row of one pixel left, then a run overflows it
    settle();
    write_cfg(16'(col_pos + 1), 16'(row_pos + 1));
    plan = '{
      beat_r(8'hC5, 1'b0), beat_r(8'h33, 1'b0),
      beat_r(8'h44, 1'b0), beat_r(8'hC2, 1'b0), beat_r(8'h00, 1'b1)
    };
    walk_plan();
    settle();
    repeat (12) @(posedge clk_i);

    $display("%0d beats decoded: %0d pixels, %0d row ends, %0d cut runs, %0d junk",
             beats_in, pixels, row_ends, eos_errs, junks);
    if (errors == 0) begin
      $display("[pcx_rle_row_decoder] OK");
    end else begin
      $display("[pcx_rle_row_decoder] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout, %0d results still expected", decoded_q.size());
    $display("[pcx_rle_row_decoder] ERROR");
    $finish;
  end

endmodule
